// ----- rtl/core/csoiir_pkg.sv -----
// Package for the cascaded second-order IIR filter.
// Holds the datapath widths, config register indexes, control word types and
// the sequencer program. No dependencies.
package csoiir_pkg;

  localparam int ACC_W   = 50;
  localparam int PROD_W  = 48;
  localparam int COEF_W  = 16;
  localparam int STATE_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int Q_FRAC  = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF0    = 3'd3;

  localparam logic signed [COEF_W-1:0] GAIN_RESET = 16'sd16384;

  localparam logic signed [ACC_W-1:0] SAT32_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT32_LO = -SAT32_HI - ACC_W'(64'sd1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd8192);

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_GAIN    = 4'd1;
  localparam step_t STEP_GLOAD   = 4'd2;
  localparam step_t STEP_SCALE   = 4'd3;
  localparam step_t STEP_MUL_C0  = 4'd4;
  localparam step_t STEP_MUL_C1  = 4'd5;
  localparam step_t STEP_MUL_C2  = 4'd6;
  localparam step_t STEP_W       = 4'd7;
  localparam step_t STEP_ACC_C3  = 4'd8;
  localparam step_t STEP_V       = 4'd9;
  localparam step_t STEP_OUT     = 4'd10;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GAIN_X,
    MUL_C0P,
    MUL_C1Q,
    MUL_C2P,
    MUL_C3Q
  } mul_sel_t;

  // _NEG ops negate the product in direct form II only
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_NEG,
    ACC_ADD,
    ACC_ADD_NEG
  } acc_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_SCALE,
    RES_W,
    RES_V,
    RES_OUT
  } res_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_NO_SEC,
    JMP_MORE_SEC,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    res_op_t  res;
    jmp_t     jmp;
    step_t    target;
  } ctrl_t;

  function automatic ctrl_t csoiir_rom(input step_t pc);
    ctrl_t w;
    unique case (pc)
      STEP_IDLE:   w = '{MUL_NONE,   ACC_HOLD,     RES_NONE,  JMP_WAIT_IN,  STEP_GAIN};
      STEP_GAIN:   w = '{MUL_GAIN_X, ACC_HOLD,     RES_NONE,  JMP_NEXT,     STEP_IDLE};
      STEP_GLOAD:  w = '{MUL_NONE,   ACC_LOAD,     RES_NONE,  JMP_NEXT,     STEP_IDLE};
      STEP_SCALE:  w = '{MUL_NONE,   ACC_HOLD,     RES_SCALE, JMP_NO_SEC,   STEP_OUT};
      STEP_MUL_C0: w = '{MUL_C0P,    ACC_HOLD,     RES_NONE,  JMP_NEXT,     STEP_IDLE};
      STEP_MUL_C1: w = '{MUL_C1Q,    ACC_LOAD_NEG, RES_NONE,  JMP_NEXT,     STEP_IDLE};
      STEP_MUL_C2: w = '{MUL_C2P,    ACC_ADD_NEG,  RES_NONE,  JMP_NEXT,     STEP_IDLE};
      STEP_W:      w = '{MUL_C3Q,    ACC_LOAD,     RES_W,     JMP_NEXT,     STEP_IDLE};
      STEP_ACC_C3: w = '{MUL_NONE,   ACC_ADD,      RES_NONE,  JMP_NEXT,     STEP_IDLE};
      STEP_V:      w = '{MUL_NONE,   ACC_HOLD,     RES_V,     JMP_MORE_SEC, STEP_MUL_C0};
      STEP_OUT:    w = '{MUL_NONE,   ACC_HOLD,     RES_OUT,   JMP_WAIT_OUT, STEP_IDLE};
      default:     w = '{MUL_NONE,   ACC_HOLD,     RES_NONE,  JMP_NEXT,     STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > SAT32_HI) begin
      r = SAT32_HI[STATE_W-1:0];
    end else if (v < SAT32_LO) begin
      r = SAT32_LO[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/csoiir_in_if.sv -----
// Input sample channel: valid/ready with sample and block-end flag.
// No dependencies.
interface csoiir_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in_block;

  modport source (output valid, output sample_in, output last_in_block, input ready);
  modport sink   (input valid, input sample_in, input last_in_block, output ready);
endinterface

// ----- rtl/core/csoiir_out_if.sv -----
// Output sample channel: valid/ready with filtered sample.
// No dependencies.
interface csoiir_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/core/cascaded_second_order_iir_filter_top.sv -----
// Cascaded second-order IIR filter, top level.
// Depends on csoiir_pkg, csoiir_in_if and csoiir_out_if.
//
// One sample at a time is scaled by a Q2.14 gain and run through up to SECTIONS
// biquad sections (direct form II or coupled form), then saturated to
// SAMPLE_BITS. A small microprogram walks one shared 16x32 multiplier and a
// 50-bit accumulator: each sample passes the gain, gain load and scale steps,
// the section steps for each section applied and the output step, six steps
// per section set by the four products through the single multiplier.
// One idle step follows, so a new sample is accepted only once the last one
// has been loaded into the output register; that load waits on a stalled output.
// The output register frees the input side, so the next sample is taken while
// a result waits. Delays clear at reset and after a beat marked last in block.
module cascaded_second_order_iir_filter_top
  import csoiir_pkg::*;
#(
  parameter int SECTIONS    = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  csoiir_in_if.sink             in_ch,
  csoiir_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic signed [STATE_W-1:0] S_HI =
    STATE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [STATE_W-1:0] S_LO = -S_HI - STATE_W'(64'sd1);

  // config
  logic signed [COEF_W-1:0]     gain_r;
  logic                         form_r;
  logic [2:0]                   sections_used_r;
  logic [CFG_DATA_W-1:0]        coef_r [SECTIONS];

  // sequencer
  step_t                        pc_r, pc_nxt;
  ctrl_t                        ctrl;
  logic [SEC_W-1:0]             sec_r;
  logic [2:0]                   sec_n;
  logic                         more_sec;

  // datapath
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          last_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [STATE_W-1:0]     v_r, w_r;
  logic signed [STATE_W-1:0]     p_r [SECTIONS];
  logic signed [STATE_W-1:0]     q_r [SECTIONS];
  logic signed [COEF_W-1:0]      mul_a;
  logic signed [STATE_W-1:0]     mul_b;
  logic signed [ACC_W-1:0]       prod_ext, rnd, base_ext, res_sum;
  logic signed [STATE_W-1:0]     base, res_sat, pq_sat, cur_p, cur_q;
  logic signed [COEF_W-1:0]      c0, c1, c2, c3;
  logic signed [SAMPLE_BITS-1:0] out_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          in_fire, out_free, out_load, form0;
  logic [CFG_IDX_W-1:0]          coef_idx;

  assign ctrl     = csoiir_rom(pc_r);
  assign form0    = !form_r;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (ctrl.res == RES_OUT) && out_free;

  assign in_ch.ready       = (ctrl.jmp == JMP_WAIT_IN);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;

  assign sec_n    = (sections_used_r > 3'(SECTIONS)) ? 3'(SECTIONS) : sections_used_r;
  assign more_sec = (3'(sec_r) + 3'd1) < sec_n;
  assign coef_idx = cfg_index - CFG_COEF0;

  assign cur_p = p_r[sec_r];
  assign cur_q = q_r[sec_r];
  assign c0 = coef_r[sec_r][0*COEF_W +: COEF_W];
  assign c1 = coef_r[sec_r][1*COEF_W +: COEF_W];
  assign c2 = coef_r[sec_r][2*COEF_W +: COEF_W];
  assign c3 = coef_r[sec_r][3*COEF_W +: COEF_W];

  always_comb begin
    unique case (ctrl.jmp)
      JMP_WAIT_IN:  pc_nxt = in_fire ? ctrl.target : pc_r;
      JMP_NO_SEC:   pc_nxt = (sec_n == 3'd0) ? ctrl.target : pc_r + step_t'(1);
      JMP_MORE_SEC: pc_nxt = more_sec ? ctrl.target : pc_r + step_t'(1);
      JMP_WAIT_OUT: pc_nxt = out_free ? ctrl.target : pc_r;
      default:      pc_nxt = pc_r + step_t'(1);
    endcase
  end

  always_comb begin
    unique case (ctrl.mul)
      MUL_GAIN_X: begin
        mul_a = gain_r;
        mul_b = {{(STATE_W-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
      end
      MUL_C0P: begin mul_a = c0; mul_b = cur_p; end
      MUL_C1Q: begin mul_a = c1; mul_b = cur_q; end
      MUL_C2P: begin mul_a = c2; mul_b = cur_p; end
      MUL_C3Q: begin mul_a = c3; mul_b = cur_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    case (ctrl.acc)
      ACC_LOAD:     acc_nxt = prod_ext;
      ACC_LOAD_NEG: acc_nxt = form0 ? -prod_ext : prod_ext;
      ACC_ADD:      acc_nxt = acc_r + prod_ext;
      ACC_ADD_NEG:  acc_nxt = form0 ? acc_r - prod_ext : acc_r + prod_ext;
      default:      acc_nxt = acc_r;
    endcase
  end

  // round half up, then add the running value and saturate
  assign rnd = (acc_r + RND_HALF) >>> Q_FRAC;

  always_comb begin
    case (ctrl.res)
      RES_W:   base = v_r;
      RES_V:   base = form0 ? w_r : v_r;
      default: base = '0;
    endcase
  end

  assign base_ext = {{(ACC_W-STATE_W){base[STATE_W-1]}}, base};
  assign res_sum  = base_ext + rnd;
  assign res_sat  = sat32(res_sum);
  assign pq_sat   = sat32({{(ACC_W-STATE_W){cur_p[STATE_W-1]}}, cur_p}
                        + {{(ACC_W-STATE_W){cur_q[STATE_W-1]}}, cur_q});

  always_comb begin
    if (v_r > S_HI) begin
      out_nxt = S_HI[SAMPLE_BITS-1:0];
    end else if (v_r < S_LO) begin
      out_nxt = S_LO[SAMPLE_BITS-1:0];
    end else begin
      out_nxt = v_r[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r            <= STEP_IDLE;
      out_valid_r     <= 1'b0;
      gain_r          <= GAIN_RESET;
      form_r          <= 1'b0;
      sections_used_r <= 3'd1;
      for (int i = 0; i < SECTIONS; i++) begin
        coef_r[i] <= '0;
        p_r[i]    <= '0;
        q_r[i]    <= '0;
      end
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAIN:     gain_r <= cfg_data[COEF_W-1:0];
          CFG_FORM:     form_r <= cfg_data[0];
          CFG_SECTIONS: sections_used_r <= cfg_data[2:0];
          default: begin
            if (cfg_index >= CFG_COEF0 && 32'(coef_idx) < SECTIONS) begin
              coef_r[coef_idx[SEC_W-1:0]] <= cfg_data;
            end
          end
        endcase
      end
      if (ctrl.res == RES_V) begin
        p_r[sec_r] <= w_r;
        q_r[sec_r] <= form0 ? cur_p : pq_sat;
      end
      if (out_load && last_r) begin
        for (int i = 0; i < SECTIONS; i++) begin
          p_r[i] <= '0;
          q_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    acc_r  <= acc_nxt;
    if (in_fire) begin
      x_r    <= in_ch.sample_in;
      last_r <= in_ch.last_in_block;
    end
    case (ctrl.res)
      RES_SCALE: begin
        v_r   <= res_sat;
        sec_r <= '0;
      end
      RES_W: w_r <= res_sat;
      RES_V: begin
        v_r   <= res_sat;
        sec_r <= sec_r + SEC_W'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      out_sample_r <= out_nxt;
    end
  end

endmodule

// ----- dv/tb_cascaded_second_order_iir_filter_top.sv -----
// Testbench for cascaded_second_order_iir_filter_top: directed and random samples
// with random stalls, checked against an in-bench fixed-point filter predictor.
// Depends on csoiir_pkg, csoiir_in_if, csoiir_out_if and the RTL top level.
module tb_cascaded_second_order_iir_filter_top
  import csoiir_pkg::*;
();

  localparam int          SECTION_COUNT = 4;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          END_CYCLES    = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  localparam logic                 FORM_DIRECT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;

  typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_mode_t;

  class biquad_scoreboard;
    int                 first_delay[SECTION_COUNT];
    int                 second_delay[SECTION_COUNT];
    logic signed [15:0] gain;
    logic               form_sel;
    logic [2:0]         sections_used;
    logic [63:0]        coef[SECTION_COUNT];
    logic signed [15:0] expected_out[$];
    int                 errors;

    function new();
      foreach (first_delay[i]) begin
        first_delay[i]  = 0;
        second_delay[i] = 0;
        coef[i]         = '0;
      end
      gain          = GAIN_RESET;
      form_sel      = FORM_DIRECT;
      sections_used = 3'd1;
      errors        = 0;
    endfunction

    function longint rnd14(longint v);
      return (v + 64'sd8192) >>> Q_FRAC;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      if (idx == CFG_GAIN) begin
        gain = data[15:0];
      end else if (idx == CFG_FORM) begin
        form_sel = data[0];
      end else if (idx == CFG_SECTIONS) begin
        sections_used = data[2:0];
      end else if (int'(idx) >= int'(CFG_COEF0) && int'(idx) < int'(CFG_COEF0) + SECTION_COUNT) begin
        coef[int'(idx) - int'(CFG_COEF0)] = data;
      end
    endfunction

    function void note_sample(logic signed [15:0] x, logic last);
      longint v, w, p, q;
      longint c[4];
      int     n;
      v = clip(rnd14(longint'(gain) * longint'(x)), 32);
      n = (sections_used > SECTION_COUNT) ? SECTION_COUNT : int'(sections_used);
      for (int i = 0; i < n; i++) begin
        p = first_delay[i];
        q = second_delay[i];
        for (int k = 0; k < 4; k++) c[k] = longint'($signed(coef[i][16*k +: 16]));
        if (form_sel == FORM_DIRECT) begin
          w = clip(v + rnd14(-(c[0] * p) - c[1] * q), 32);
          v = clip(w + rnd14(c[2] * p + c[3] * q), 32);
          second_delay[i] = int'(p);
          first_delay[i]  = int'(w);
        end else begin
          first_delay[i]  = int'(clip(v + rnd14(c[0] * p + c[1] * q), 32));
          second_delay[i] = int'(clip(p + q, 32));
          v = clip(v + rnd14(c[2] * p + c[3] * q), 32);
        end
      end
      expected_out.push_back(16'(clip(v, 16)));
      if (last) begin
        foreach (first_delay[i]) begin
          first_delay[i]  = 0;
          second_delay[i] = 0;
        end
      end
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: sample_out expected none, actual %0d", $time, got);
        return;
      end
      want = expected_out.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: sample_out expected %0d, actual %0d", $time, want, got);
      end
    endfunction

    function int outstanding();
      return expected_out.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  csoiir_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  csoiir_out_if #(.SAMPLE_BITS(16)) out_ch ();

  cascaded_second_order_iir_filter_top #(.SECTIONS(4), .SAMPLE_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  biquad_scoreboard sb;
  int               hold_req  = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               rx_left   = 0;
  rx_mode_t         rx_mode   = RX_STEADY;
  int unsigned      cycle_count = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[cascaded_second_order_iir_filter_top] ERROR");
      $finish;
    end
  end

  // result side: check each beat, then pick next ready
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check_sample(out_ch.sample_out);
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        RX_STEADY: out_ch.ready <= 1'b1;
        RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 9) >= 3);
        default:   out_ch.ready <= ($urandom_range(0, 9) >= 7);
      endcase
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  task automatic set_filter(input logic [63:0] g, input logic [63:0] f, input logic [63:0] s,
                            input logic [63:0] c0, input logic [63:0] c1,
                            input logic [63:0] c2, input logic [63:0] c3);
    cfg_write(CFG_GAIN, g);
    cfg_write(CFG_FORM, f);
    cfg_write(CFG_SECTIONS, s);
    cfg_write(CFG_COEF0, c0);
    cfg_write(CFG_COEF0 + 3'd1, c1);
    cfg_write(CFG_COEF0 + 3'd2, c2);
    cfg_write(CFG_COEF0 + 3'd3, c3);
    cfg_we <= 1'b0;
  endtask

  task automatic offer_sample(input logic signed [15:0] x, input logic last);
    in_ch.valid         <= 1'b1;
    in_ch.sample_in     <= x;
    in_ch.last_in_block <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(x, last);
  endtask

  task automatic pause_input(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly stable poles (|a2| < 1, |a1| < 1 + a2), or anything at all
  function automatic logic [63:0] pick_coefs(input bit wild);
    logic signed [15:0] a1, a2;
    if (wild) return {$urandom, $urandom};
    a1 = 16'($signed($urandom_range(0, 24000)) - 12000);
    a2 = 16'($signed($urandom_range(0, 16000)) - 4000);
    return {16'($urandom), 16'($urandom), a2, a1};
  endfunction

  task automatic random_config(input bit wild);
    logic [63:0] g, f, s;
    g = {$urandom, $urandom};
    f = {$urandom, $urandom};
    s = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       g[15:0] = GAIN_RESET;
      1:       g[15:0] = 16'($urandom);
      default: g[15:0] = 16'($urandom_range(1024, 12000));
    endcase
    s[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, {$urandom, $urandom});
    set_filter(g, f, s, pick_coefs(wild), pick_coefs(wild), pick_coefs(wild), pick_coefs(wild));
  endtask

  task automatic random_phase(input int count);
    int   burst_left, block_left;
    logic last;
    burst_left = $urandom_range(1, 24);
    block_left = $urandom_range(1, 40);
    for (int k = 0; k < count; k++) begin
      block_left--;
      last = (block_left == 0) || ($urandom_range(0, 49) == 0);
      if (block_left == 0) block_left = $urandom_range(1, 40);
      offer_sample(pick_sample(), last);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
      end
    end
    drain(SETTLE_CYCLES);
  endtask

  initial begin
    sb                  = new();
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.last_in_block = 1'b0;
    out_ch.ready        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unity gain, one direct form section, zero coefficients
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh8000, 1'b0);
    offer_sample(16'sh0000, 1'b0);
    offer_sample(-16'sd1, 1'b0);
    offer_sample(16'sd1, 1'b1);
    drain(SETTLE_CYCLES);

    // most negative gain, no sections
    set_filter(64'hFFFF_FFFF_FFFF_8000, FORM_DIRECT, 64'd0, '0, '0, '0, '0);
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh8000, 1'b0);
    offer_sample(-16'sd1, 1'b0);
    offer_sample(16'sd16384, 1'b1);
    drain(SETTLE_CYCLES);

    // largest gain, section count above four, extreme coefficients
    set_filter(64'h7FFF, FORM_DIRECT, 64'd7, 64'h8000_7FFF_8000_7FFF,
               64'h7FFF_8000_7FFF_8000, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF);
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh8000, 1'b0);
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sh8000, 1'b0);
    offer_sample(16'sh7FFF, 1'b1);
    drain(SETTLE_CYCLES);

    // coupled form, stray writes to the unused index, block left open
    cfg_write(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(CFG_FORM, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(CFG_GAIN, 64'h0000_0000_0000_2000);
    cfg_write(CFG_UNUSED, 64'h0);
    cfg_we <= 1'b0;
    offer_sample(16'sh8000, 1'b0);
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sd1, 1'b1);
    offer_sample(-16'sd1, 1'b0);
    offer_sample(16'sd12345, 1'b0);
    drain(SETTLE_CYCLES);

    // back to direct form on live delays, two sections
    set_filter(GAIN_RESET, FORM_DIRECT, 64'd2, 64'h0800_1000_1800_E000,
               64'hF000_0400_2000_C800, '0, '0);
    offer_sample(16'sd3000, 1'b0);
    offer_sample(-16'sd20000, 1'b0);
    offer_sample(16'sh7FFF, 1'b0);
    offer_sample(16'sd0, 1'b0);
    offer_sample(-16'sd7, 1'b1);
    drain(SETTLE_CYCLES);

    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph % 3 == 2);
      if (ph == 2 || ph == 5) hold_req++;
      random_phase(85);
    end

    drain(END_CYCLES);
    if (sb.errors == 0) begin
      $display("[cascaded_second_order_iir_filter_top] OK");
    end else begin
      $display("[cascaded_second_order_iir_filter_top] ERROR");
    end
    $finish;
  end

endmodule
